@@ design/aoc_pkg.sv @@
`timescale 1ns / 1ps

package aoc_pkg;

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DIV_STEPS = 16;
  // s1, s2, s3, s4, divider steps, product stage, output register
  localparam int unsigned NUM_STAGES = DIV_STEPS + 6;
  localparam int unsigned DIV_BASE   = 4;
  localparam int unsigned MIX_STAGE  = DIV_BASE + DIV_STEPS;
  localparam int unsigned OUT_STAGE  = MIX_STAGE + 1;

  localparam logic [16:0] Q_ONE       = 17'h10000;
  localparam logic [25:0] Q_HALF      = 26'h0008000;
  localparam logic [8:0]  OPACITY_ONE = 9'd256;

  typedef enum logic [0:0] {
    REG_LAYER_OPACITY = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t base;
    rgb_t over;
  } pix_t;

  typedef struct packed {
    pix_t        pix;
    logic [16:0] ab;
    logic [15:0] prod;
  } s1_t;

  typedef struct packed {
    pix_t        pix;
    logic [16:0] ab;
    logic [16:0] ao;
  } s2_t;

  typedef struct packed {
    pix_t        pix;
    logic [16:0] ao;
    logic [16:0] keep;
  } s3_t;

  typedef struct packed {
    pix_t        pix;
    logic [16:0] af;
    logic [16:0] rem;
    logic [15:0] quo;
    logic [7:0]  alpha;
    logic        zero;
    logic        sat;
  } div_t;

  typedef struct packed {
    logic [7:0]  alpha;
    logic        zero;
    logic [24:0] pb_red;
    logic [24:0] pb_green;
    logic [24:0] pb_blue;
    logic [24:0] po_red;
    logic [24:0] po_green;
    logic [24:0] po_blue;
  } mix_t;

endpackage

@@ design/alpha_over_composite.sv @@
`timescale 1ns / 1ps
// Non-premultiplied over of an ARGB8888 overlay pixel onto a base pixel.
// Throughput: one pixel pair per cycle while out_stall is low; bubbles in the pipeline are squeezed out.
// Depth is set by the weight divider, sixteen stages of one quotient bit each.
// Reset (rst, synchronous): empties the pipeline and sets layer_opacity to 256.
module alpha_over_composite (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 base_alpha,
  input  logic [7:0]                 base_red,
  input  logic [7:0]                 base_green,
  input  logic [7:0]                 base_blue,
  input  logic [7:0]                 over_alpha,
  input  logic [7:0]                 over_red,
  input  logic [7:0]                 over_green,
  input  logic [7:0]                 over_blue,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_alpha,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue
);
  import aoc_pkg::*;

  logic [8:0] layer_opacity;
  logic       reg_sel;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  s1_t  s1;
  s2_t  s2;
  s3_t  s3;
  div_t s4;
  div_t dv      [DIV_STEPS];
  div_t div_src [DIV_STEPS];
  div_t div_res [DIV_STEPS];
  mix_t m1;

  logic        accept;
  logic [8:0]  lo;
  logic [16:0] oa_prod;
  logic [16:0] p_fold;
  logic [33:0] keep_prod;
  logic [16:0] af;
  logic [25:0] alpha_sum;
  logic [17:0] rem2 [DIV_STEPS];
  logic [16:0] w;
  logic [16:0] wc;
  logic [25:0] sum_red;
  logic [25:0] sum_green;
  logic [25:0] sum_blue;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_LAYER_OPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_opacity <= OPACITY_ONE;
    end else if (psel && penable && pwrite && reg_sel) begin
      layer_opacity <= pwdata[8:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_sel) begin
      prdata = {23'd0, layer_opacity};
    end
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[OUT_STAGE] = !vld[OUT_STAGE] || !out_stall;
    for (int i = OUT_STAGE - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall = rst || !en[0];
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= accept;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 1: base opacity and overlay alpha times layer opacity
  assign lo      = layer_opacity[8] ? OPACITY_ONE : layer_opacity;
  assign oa_prod = {9'd0, over_alpha} * {8'd0, lo};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1.pix.base.red   <= base_red;
      s1.pix.base.green <= base_green;
      s1.pix.base.blue  <= base_blue;
      s1.pix.over.red   <= over_red;
      s1.pix.over.green <= over_green;
      s1.pix.over.blue  <= over_blue;
      // x * 65536 / 255 is x * 257 plus one at full scale
      s1.ab   <= {1'b0, base_alpha, base_alpha} + {16'd0, (base_alpha == 8'hff)};
      s1.prod <= oa_prod[15:0];
    end
  end

  // stage 2: scaled overlay opacity, p * 256 / 255 = p + p / 255
  assign p_fold = {1'b0, s1.prod} + 17'd1 + {9'd0, s1.prod[15:8]};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2.pix <= s1.pix;
      s2.ab  <= s1.ab;
      s2.ao  <= {1'b0, s1.prod} + {8'd0, p_fold[16:8]};
    end
  end

  // stage 3: product of the transparencies
  assign keep_prod = {17'd0, Q_ONE - s2.ab} * {17'd0, Q_ONE - s2.ao};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3.pix  <= s2.pix;
      s3.ao   <= s2.ao;
      s3.keep <= keep_prod[32:16];
    end
  end

  // stage 4: result opacity, rounded alpha and divider set-up
  assign af        = Q_ONE - s3.keep;
  assign alpha_sum = {1'b0, af, 8'd0} - {9'd0, af} + Q_HALF;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4.pix   <= s3.pix;
      s4.af    <= af;
      s4.rem   <= s3.ao;
      s4.quo   <= '0;
      s4.alpha <= alpha_sum[23:16];
      s4.zero  <= (af == 17'd0);
      // weight saturates at 1.0 whenever ao reaches af
      s4.sat   <= (s3.ao >= af);
    end
  end

  // restoring divider, one quotient bit per stage
  always_comb begin
    div_src[0] = s4;
    for (int i = 1; i < DIV_STEPS; i++) begin
      div_src[i] = dv[i-1];
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_res[i] = div_src[i];
      rem2[i]    = {div_src[i].rem, 1'b0};
      if (rem2[i] >= {1'b0, div_src[i].af}) begin
        div_res[i].rem = 17'(rem2[i] - {1'b0, div_src[i].af});
        div_res[i].quo = {div_src[i].quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        div_res[i].rem = rem2[i][16:0];
        div_res[i].quo = {div_src[i].quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (en[DIV_BASE+i]) begin
        dv[i] <= div_res[i];
      end
    end
  end

  // channel products
  assign w  = dv[DIV_STEPS-1].sat ? Q_ONE : {1'b0, dv[DIV_STEPS-1].quo};
  assign wc = Q_ONE - w;

  always_ff @(posedge clk) begin
    if (en[MIX_STAGE]) begin
      m1.alpha    <= dv[DIV_STEPS-1].alpha;
      m1.zero     <= dv[DIV_STEPS-1].zero;
      m1.pb_red   <= {17'd0, dv[DIV_STEPS-1].pix.base.red}   * {8'd0, wc};
      m1.pb_green <= {17'd0, dv[DIV_STEPS-1].pix.base.green} * {8'd0, wc};
      m1.pb_blue  <= {17'd0, dv[DIV_STEPS-1].pix.base.blue}  * {8'd0, wc};
      m1.po_red   <= {17'd0, dv[DIV_STEPS-1].pix.over.red}   * {8'd0, w};
      m1.po_green <= {17'd0, dv[DIV_STEPS-1].pix.over.green} * {8'd0, w};
      m1.po_blue  <= {17'd0, dv[DIV_STEPS-1].pix.over.blue}  * {8'd0, w};
    end
  end

  // output register: round and drop a fully transparent result to zero
  assign sum_red   = {1'b0, m1.pb_red}   + {1'b0, m1.po_red}   + Q_HALF;
  assign sum_green = {1'b0, m1.pb_green} + {1'b0, m1.po_green} + Q_HALF;
  assign sum_blue  = {1'b0, m1.pb_blue}  + {1'b0, m1.po_blue}  + Q_HALF;

  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      out_alpha <= m1.zero ? 8'd0 : m1.alpha;
      out_red   <= m1.zero ? 8'd0 : sum_red[23:16];
      out_green <= m1.zero ? 8'd0 : sum_green[23:16];
      out_blue  <= m1.zero ? 8'd0 : sum_blue[23:16];
    end
  end

  assign out_valid = vld[OUT_STAGE];

endmodule

@@ design/aoc_checker.sv @@
`timescale 1ns / 1ps

module aoc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [aoc_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata,
  input logic                       pready,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [7:0]                 base_alpha,
  input logic [7:0]                 base_red,
  input logic [7:0]                 base_green,
  input logic [7:0]                 base_blue,
  input logic [7:0]                 over_alpha,
  input logic [7:0]                 over_red,
  input logic [7:0]                 over_green,
  input logic [7:0]                 over_blue,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [7:0]                 out_alpha,
  input logic [7:0]                 out_red,
  input logic [7:0]                 out_green,
  input logic [7:0]                 out_blue
);
  import aoc_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // input is held back only when every stage is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("request refused with room in the pipeline");

  // a written opacity reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == {ADDR_W{1'b0}})
      |=> (paddr != {ADDR_W{1'b0}} || prdata == {23'd0, $past(pwdata[8:0])}))
    else $error("layer opacity readback mismatch");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_alpha) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

endmodule

bind alpha_over_composite aoc_checker u_aoc_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import aoc_pkg::*;

  localparam longint unsigned UNITY = 65536;
  localparam longint unsigned HALF = 32768;
  localparam logic [8:0] FULL_OPACITY = 9'd256;
  localparam logic [ADDR_W-1:0] OPACITY_ADDR = ADDR_W'(4 * REG_LAYER_OPACITY);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (REG_LAYER_OPACITY + 1));
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] base_alpha;
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] over_alpha;
    logic [7:0] over_red;
    logic [7:0] over_green;
    logic [7:0] over_blue;
  } pixel_pair_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_pixel_t;

  class composite_scoreboard;
    out_pixel_t pending[$];
    logic [8:0] opacity;
    int errors;

    function new();
      opacity = FULL_OPACITY;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      if (addr == OPACITY_ADDR) opacity = data[8:0];
    endfunction

    function logic [7:0] blend(input logic [7:0] b, input logic [7:0] o,
                               input longint unsigned w);
      longint unsigned acc;
      acc = 64'(b) * (UNITY - w) + 64'(o) * w + HALF;
      return 8'(acc >> 16);
    endfunction

    function out_pixel_t composite(input pixel_pair_t p);
      longint unsigned lo, ab, ao, keep, af, w;
      out_pixel_t r;
      // saturate opacity above unity
      lo = (opacity > FULL_OPACITY) ? 64'(FULL_OPACITY) : 64'(opacity);
      ab = (64'(p.base_alpha) << 16) / 255;
      ao = (64'(p.over_alpha) * lo * 256) / 255;
      keep = ((UNITY - ab) * (UNITY - ao)) >> 16;
      af = UNITY - keep;
      if (af == 0) return '0;
      r.alpha = 8'((af * 255 + HALF) >> 16);
      w = (ao << 16) / af;
      if (w > UNITY) w = UNITY;
      r.red = blend(p.base_red, p.over_red, w);
      r.green = blend(p.base_green, p.over_green, w);
      r.blue = blend(p.base_blue, p.over_blue, w);
      return r;
    endfunction

    function void note_request(input pixel_pair_t p);
      pending.push_back(composite(p));
    endfunction

    task field_check(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(input out_pixel_t got);
      out_pixel_t want;
      if (pending.size() == 0) begin
        report("result with no request waiting");
        return;
      end
      want = pending.pop_front();
      field_check("out_alpha", got.alpha, want.alpha);
      field_check("out_red", got.red, want.red);
      field_check("out_green", got.green, want.green);
      field_check("out_blue", got.blue, want.blue);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  pixel_pair_t req;
  logic out_valid, out_stall;
  logic [7:0] out_alpha, out_red, out_green, out_blue;

  composite_scoreboard sb;
  bit calm;
  int unsigned stall_left;
  int unsigned cycles;

  alpha_over_composite u_top (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .base_alpha (req.base_alpha),
    .base_red   (req.base_red),
    .base_green (req.base_green),
    .base_blue  (req.base_blue),
    .over_alpha (req.over_alpha),
    .over_red   (req.over_red),
    .over_green (req.over_green),
    .over_blue  (req.over_blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_alpha  (out_alpha),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    out_pixel_t got;
    if (rst === 1'b0) begin
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_request(req);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_alpha, out_red, out_green, out_blue};
        sb.check_result(got);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  function automatic pixel_pair_t pix(input int a, b, c, d, e, f, g, h);
    return '{8'(a), 8'(b), 8'(c), 8'(d), 8'(e), 8'(f), 8'(g), 8'(h)};
  endfunction

  function automatic logic [7:0] rand_alpha();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_pair_t rand_pixel();
    pixel_pair_t p;
    p = pixel_pair_t'({$urandom, $urandom});
    p.base_alpha = rand_alpha();
    p.over_alpha = rand_alpha();
    return p;
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(input pixel_pair_t p);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      req <= rand_pixel();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [31:0] data, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_opacity();
    logic [31:0] rdata;
    apb_xfer(1'b0, OPACITY_ADDR, 32'h0, rdata);
    if (rdata[8:0] !== sb.opacity)
      sb.report($sformatf("layer_opacity read %0d want %0d", rdata[8:0], sb.opacity));
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [8:0] value);
    logic [31:0] data, rdata;
    // junk in the unused upper bits
    data = {$urandom} & 32'hffff_fe00 | 32'(value);
    apb_xfer(1'b1, addr, data, rdata);
    sb.write_reg(addr, data);
    check_opacity();
  endtask

  // hold off until every request has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned settings[7];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    req = '0;
    out_stall = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    cycles = 0;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_opacity();

    // corners at unity opacity
    send_pixel(pix(0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(pix(0, 255, 255, 255, 0, 255, 255, 255));
    send_pixel(pix(255, 255, 255, 255, 255, 0, 0, 0));
    send_pixel(pix(255, 0, 0, 0, 255, 255, 255, 255));
    send_pixel(pix(255, 12, 34, 56, 0, 200, 100, 50));
    send_pixel(pix(0, 200, 100, 50, 255, 12, 34, 56));
    send_pixel(pix(0, 255, 0, 255, 1, 0, 255, 0));
    send_pixel(pix(1, 255, 255, 255, 0, 0, 0, 0));
    send_pixel(pix(128, 170, 85, 255, 128, 85, 170, 0));
    send_pixel(pix(255, 255, 0, 128, 127, 0, 255, 127));
    send_pixel(pix(64, 1, 2, 3, 200, 254, 253, 252));
    send_pixel(pix(170, 85, 170, 85, 85, 170, 85, 170));
    drain();
    // zero opacity hides the overlay; transparent base gives an empty result
    write_reg(OPACITY_ADDR, 9'd0);
    send_pixel(pix(0, 10, 20, 30, 255, 40, 50, 60));
    send_pixel(pix(200, 10, 20, 30, 255, 240, 250, 255));
    drain();
    write_reg(OPACITY_ADDR, 9'd511);
    send_pixel(pix(100, 0, 255, 0, 200, 255, 0, 255));
    send_pixel(pix(0, 5, 5, 5, 128, 250, 250, 250));
    drain();
    write_reg(OPACITY_ADDR, 9'd257);
    send_pixel(pix(128, 90, 60, 30, 255, 30, 60, 90));
    drain();
    write_reg(OPACITY_ADDR, 9'd1);
    send_pixel(pix(0, 0, 0, 0, 1, 255, 255, 255));
    send_pixel(pix(0, 0, 0, 0, 255, 255, 255, 255));
    drain();
    // unmapped register must be ignored
    write_reg(SPARE_ADDR, 9'h0aa);
    send_pixel(pix(60, 200, 10, 100, 255, 20, 220, 120));
    drain();

    settings = '{256, 1, 255, 300, $urandom_range(0, 511), 0, 128};
    foreach (settings[i]) begin
      write_reg(OPACITY_ADDR, 9'(settings[i]));
      calm = ($urandom_range(0, 3) == 0);
      repeat (86) send_pixel(rand_pixel());
      drain();
    end
    calm = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/aoc_pkg.sv
design/alpha_over_composite.sv
design/aoc_checker.sv
verif/tb.sv
